// File: rtl/dhash_pkg.sv
// ----------------------------------------------------------------------------
// dhash_pkg
// Shared constants and types of the double hashing table.
// ----------------------------------------------------------------------------
package dhash_pkg;

    localparam int TABLE_SLOTS_DEF = 127;
    localparam int KEY_W           = 31;
    localparam int SLOT_OUT_W      = 7;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

endpackage

// File: rtl/double_hash_table.sv
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressing hash table with double hashing, insert and search.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request item: s_tuser is the operation (insert or
//   search), s_tdata the key. m_axis returns one item per request: m_tuser is
//   the status, m_tdata the slot index (0 when full or not found).
//   The home slot is key mod TABLE_SLOTS, the probe step
//   1 + key mod (TABLE_SLOTS - 1); TABLE_SLOTS should be prime.
//   Both remainders come from one shared multiplier by reciprocal
//   multiplication, one after the other.
//   Each probe is one registered RAM read followed by a check.
//   An insert into a full table skips the remainders and the probes and
//   goes straight to S_OUT. Only one item is in flight.
//   After reset the block sweeps the slot RAM to clear it, with s_tready
//   low. When the receiver stalls, the result is held in the output
//   register and the next request waits in the sequencer.
// ----------------------------------------------------------------------------
module double_hash_table
    import dhash_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] key, [31] zero
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] slot_index, [7] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int RW = KEY_W + 1;
    localparam logic [CW-1:0] SLOTS_C  = CW'(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST_N_C = IW'(TABLE_SLOTS - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HOME  = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     clr_reg, clr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [IW-1:0]     home_reg, home_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     step_reg, step_next;
    logic [IW-1:0]     n_reg, n_next;
    status_t           res_status_reg, res_status_next;
    logic [IW-1:0]     res_idx_reg, res_idx_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [SLOT_OUT_W-1:0] m_idx_reg, m_idx_next;

    logic              rem_start;
    logic              rem_sel;
    logic              rem_done;
    logic [CW-1:0]     rem_val;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [RW-1:0]     ram_wdata;
    logic              ram_re;
    logic [RW-1:0]     ram_rdata;

    logic              rd_valid;
    logic [KEY_W-1:0]  rd_key;
    logic [IW:0]       sum;
    logic [IW-1:0]     nxt_idx;
    logic              n_last;
    logic [IW+SLOT_OUT_W-1:0] idx_wide;

    dhash_rem #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .CW          (CW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .sel      (rem_sel),
        .dividend (key_next),
        .done     (rem_done),
        .rem      (rem_val)
    );

    dhash_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_valid = ram_rdata[KEY_W];
    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign n_last   = (n_reg == LAST_N_C);
    assign idx_wide = {{SLOT_OUT_W{1'b0}}, res_idx_reg};

    // next probe slot: idx + step stays below twice the table size
    always_comb
    begin
        sum = {1'b0, idx_reg} + {1'b0, step_reg};
        if (sum >= (IW+1)'(TABLE_SLOTS))
        begin
            nxt_idx = IW'(sum - (IW+1)'(TABLE_SLOTS));
        end
        else
        begin
            nxt_idx = sum[IW-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        home_next       = home_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        n_next          = n_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_idx_next      = m_idx_reg;
        rem_start       = 1'b0;
        rem_sel         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {1'b1, key_reg};
        ram_re          = 1'b0;
        s_tready        = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_N_C)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next  = s_tuser[0];
                    key_next = s_tdata[KEY_W-1:0];
                    if (s_tuser[0] == OP_INSERT && count_reg == SLOTS_C)
                    begin
                        res_status_next = ST_FULL;
                        res_idx_next    = '0;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        rem_start  = 1'b1;
                        state_next = S_HOME;
                    end
                end
            end
            S_HOME:
            begin
                rem_sel = 1'b1;
                if (rem_done)
                begin
                    home_next  = rem_val[IW-1:0];
                    idx_next   = rem_val[IW-1:0];
                    rem_start  = 1'b1;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (rem_done)
                begin
                    step_next  = rem_val[IW-1:0] + 1'b1;
                    n_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_OUT;
                if (op_reg == OP_INSERT)
                begin
                    if (!rd_valid)
                    begin
                        ram_we          = 1'b1;
                        count_next      = count_reg + 1'b1;
                        res_status_next = ST_INSERTED;
                        res_idx_next    = idx_reg;
                    end
                    else if (n_last)
                    begin
                        res_status_next = ST_FULL;
                        res_idx_next    = '0;
                    end
                    else
                    begin
                        idx_next   = nxt_idx;
                        n_next     = n_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    if (rd_valid && rd_key == key_reg)
                    begin
                        res_status_next = ST_FOUND;
                        res_idx_next    = idx_reg;
                    end
                    else if (!rd_valid || nxt_idx == home_reg || n_last)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_idx_next    = '0;
                    end
                    else
                    begin
                        idx_next   = nxt_idx;
                        n_next     = n_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_OUT:
            begin
                // wait for the output register to drain
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_idx_next    = idx_wide[SLOT_OUT_W-1:0];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        home_reg       <= home_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        m_status_reg   <= m_status_next;
        m_idx_reg      <= m_idx_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_idx_reg};
    assign m_tuser  = m_status_reg;

endmodule

// File: rtl/dhash_ram.sv
// ----------------------------------------------------------------------------
// dhash_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module dhash_ram
    import dhash_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = TABLE_SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/dhash_rem.sv
// ----------------------------------------------------------------------------
// dhash_rem
// Remainder unit: key mod TABLE_SLOTS or key mod (TABLE_SLOTS - 1) by
// reciprocal multiplication on one shared multiplier, one key at a time.
// ----------------------------------------------------------------------------
module dhash_rem
    import dhash_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
    parameter int CW          = $clog2(TABLE_SLOTS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             sel,        // 0: mod TABLE_SLOTS, 1: mod TABLE_SLOTS - 1
    input  logic [KEY_W-1:0] dividend,
    output logic             done,
    output logic [CW-1:0]    rem
);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_MUL  = 4'b0010,
        P_BACK = 4'b0100,
        P_FIX  = 4'b1000
    } phase_t;

    localparam logic [KEY_W-1:0] DIV_HOME   = KEY_W'(TABLE_SLOTS);
    localparam logic [KEY_W-1:0] DIV_STEP   = KEY_W'(TABLE_SLOTS - 1);
    localparam logic [KEY_W-1:0] RECIP_HOME = KEY_W'((64'd1 << KEY_W) / TABLE_SLOTS);
    localparam logic [KEY_W-1:0] RECIP_STEP = KEY_W'((64'd1 << KEY_W) / (TABLE_SLOTS - 1));

    phase_t               phase_reg, phase_next;
    logic                 done_reg, done_next;
    logic                 sel_reg, sel_next;
    logic [KEY_W-1:0]     dvd_reg, dvd_next;
    logic [2*KEY_W-1:0]   prod_reg, prod_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [KEY_W-1:0]     div_sel;
    logic [KEY_W-1:0]     recip_sel;
    logic [KEY_W-1:0]     mul_a;
    logic [KEY_W-1:0]     mul_b;
    logic [2*KEY_W-1:0]   mul_p;
    logic [CW:0]          part;

    assign div_sel   = sel_reg ? DIV_STEP : DIV_HOME;
    assign recip_sel = sel_reg ? RECIP_STEP : RECIP_HOME;

    // first pass: key * recip gives the quotient estimate in the upper half,
    // second pass: estimate * divisor
    assign mul_a = (phase_reg == P_BACK) ? prod_reg[2*KEY_W-1:KEY_W] : dvd_reg;
    assign mul_b = (phase_reg == P_BACK) ? div_sel : recip_sel;
    assign mul_p = {{KEY_W{1'b0}}, mul_a} * {{KEY_W{1'b0}}, mul_b};

    // estimate is at most one short, so the difference is below twice the
    // divisor and its low bits are enough
    assign part = dvd_reg[CW:0] - prod_reg[CW:0];

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        sel_next   = sel_reg;
        dvd_next   = dvd_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        unique case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    sel_next   = sel;
                    dvd_next   = dividend;
                    phase_next = P_MUL;
                end
            end
            P_MUL:
            begin
                prod_next  = mul_p;
                phase_next = P_BACK;
            end
            P_BACK:
            begin
                prod_next  = mul_p;
                phase_next = P_FIX;
            end
            P_FIX:
            begin
                if (part >= div_sel[CW:0])
                begin
                    rem_next = CW'(part - div_sel[CW:0]);
                end
                else
                begin
                    rem_next = part[CW-1:0];
                end
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        dvd_reg  <= dvd_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: tb/sv/tb_double_hash_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_hash_table
// Self-checking bench for the double hashing table: a short directed run
// covers empty-table searches, extreme keys, home-slot collisions, duplicate
// inserts and the top slot. Then a random mix fills the table until inserts
// are refused, with random stalls and gaps on both streams. A scoreboard
// keeps its own copy of the table and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_double_hash_table;
    import dhash_pkg::*;

    localparam int        SLOTS       = TABLE_SLOTS_DEF;
    localparam int        N_RANDOM    = 800;
    localparam int        QUIET_TAIL  = 100;
    localparam int        SETTLE_CYC  = 400;
    localparam longint    CYCLE_LIMIT = 1_000_000;

    typedef struct {
        status_t      status;
        logic [6:0]   slot;
        op_t          op;
        logic [30:0]  key;
    } reply_t;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the table, predicts one reply per request
    // ------------------------------------------------------------------------
    class table_scoreboard;
        logic [30:0]  slot_key [SLOTS];
        bit           slot_used [SLOTS];
        int unsigned  fill_count;
        reply_t       expected_replies [$];
        int unsigned  n_inserted, n_refused, n_found, n_missing;

        function new();
            fill_count = 0;
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
        endfunction

        function reply_t predict_reply(op_t op, logic [30:0] key);
            reply_t       r;
            int unsigned  idx;
            int unsigned  home;
            int unsigned  stride;
            int unsigned  n;
            r.op     = op;
            r.key    = key;
            r.slot   = '0;
            idx      = key % SLOTS;
            home     = idx;
            stride   = 1 + key % (SLOTS - 1);
            if (op == OP_INSERT)
            begin
                r.status = ST_FULL;
                if (fill_count < SLOTS)
                begin
                    for (n = 0; n < SLOTS; n++)
                    begin
                        if (!slot_used[idx])
                        begin
                            slot_key[idx]  = key;
                            slot_used[idx] = 1'b1;
                            fill_count++;
                            r.status = ST_INSERTED;
                            r.slot   = idx[6:0];
                            break;
                        end
                        idx = (idx + stride) % SLOTS;
                    end
                end
            end
            else
            begin
                r.status = ST_NOT_FOUND;
                for (n = 0; n < SLOTS && slot_used[idx]; n++)
                begin
                    if (slot_key[idx] == key)
                    begin
                        r.status = ST_FOUND;
                        r.slot   = idx[6:0];
                        break;
                    end
                    idx = (idx + stride) % SLOTS;
                    if (idx == home)
                        break;
                end
            end
            return r;
        endfunction

        function void note_request(op_t op, logic [30:0] key);
            reply_t r;
            r = predict_reply(op, key);
            case (r.status)
                ST_INSERTED: n_inserted++;
                ST_FULL:     n_refused++;
                ST_FOUND:    n_found++;
                default:     n_missing++;
            endcase
            expected_replies.push_back(r);
        endfunction

        // returns an empty string when the item matches
        function string check_result(logic [1:0] status, logic [6:0] slot);
            reply_t r;
            string  msg;
            if (expected_replies.size() == 0)
                return $sformatf("result with nothing pending: status %0d slot %0d",
                                 status, slot);
            r   = expected_replies.pop_front();
            msg = "";
            if (status !== r.status)
                msg = {msg, $sformatf(" status %0d want %0d", status, r.status)};
            if (slot !== r.slot)
                msg = {msg, $sformatf(" slot %0d want %0d", slot, r.slot)};
            if (msg != "")
                msg = {$sformatf("%s key %0d:", r.op.name(), r.key), msg};
            return msg;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [30:0] key, [31] zero
    logic [0:0]  s_tuser  = '0;    // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [6:0] slot_index, [7] zero
    logic [1:0]  m_tuser;          // [1:0] status

    double_hash_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    table_scoreboard sb = new();

    longint       cycle_count = 0;
    int unsigned  fail_count  = 0;
    int unsigned  sent_count  = 0;
    bit           idle_on     = 1'b0;
    int unsigned  stall_left  = 0;
    string        rx_msg;
    logic [30:0]  inserted_keys [$];

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d:%s %s", cycle_count, "", msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check accepted items, stall in short bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                rx_msg = sb.check_result(m_tuser, m_tdata[6:0]);
                if (rx_msg != "")
                    report_mismatch(rx_msg);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // request side: one item, held until accepted
    task automatic send_request(op_t op, logic [30:0] key);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, key};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, key);
        if (op == OP_INSERT)
            inserted_keys.push_back(key);
        sent_count++;
    endtask

    task automatic wait_until_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [30:0] pick_key(bit prefer_known);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (prefer_known && inserted_keys.size() != 0 && sel < 5)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        case (sel % 4)
            0:       return 31'($urandom);
            1:       return 31'($urandom_range(0, 400));
            // keys sharing a few home slots
            2:       return 31'($urandom_range(0, 60) * SLOTS + $urandom_range(0, 2));
            default: return 31'(31'h7FFF_FFFF - $urandom_range(0, 300));
        endcase
    endfunction

    initial
    begin
        int unsigned i;
        op_t         op;
        logic [30:0] key;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        send_request(OP_SEARCH, 31'd0);
        send_request(OP_SEARCH, 31'h7FFF_FFFF);
        send_request(OP_INSERT, 31'd0);
        send_request(OP_INSERT, 31'h7FFF_FFFF);
        send_request(OP_INSERT, 31'd0);          // duplicate goes one step on
        send_request(OP_INSERT, 31'd127);        // same home as key 0
        send_request(OP_INSERT, 31'd254);
        send_request(OP_SEARCH, 31'd0);
        send_request(OP_SEARCH, 31'd254);
        send_request(OP_SEARCH, 31'd381);        // walk stops at an empty slot
        send_request(OP_SEARCH, 31'h7FFF_FFFF);
        send_request(OP_SEARCH, 31'd126);
        send_request(OP_INSERT, 31'd126);        // top slot
        send_request(OP_SEARCH, 31'd126);
        send_request(OP_INSERT, 31'h5555_5555);
        send_request(OP_INSERT, 31'h2AAA_AAAA);
        send_request(OP_SEARCH, 31'h5555_5555);
        send_request(OP_SEARCH, 31'h2AAA_AAAA);
        send_request(OP_SEARCH, 31'h7FFF_FFFE);

        // random part: inserts fill the table, then get refused
        for (i = 0; i < N_RANDOM; i++)
        begin
            idle_on = (i < N_RANDOM - QUIET_TAIL);
            if (i == N_RANDOM / 2)
            begin
                // drop valid so the last item is not taken twice
                s_tvalid <= 1'b0;
                wait_until_drained();
            end
            op  = ($urandom_range(0, 99) < 35) ? OP_INSERT : OP_SEARCH;
            key = pick_key(op == OP_SEARCH);
            send_request(op, key);
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        wait_until_drained();
        repeat (SETTLE_CYC) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d refused on a full table",
                 sent_count, sb.n_inserted, sb.n_refused);
        $display("searches: %0d found, %0d missing; %0d of %0d slots in use; %0d mismatches",
                 sb.n_found, sb.n_missing, sb.fill_count, SLOTS, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/dhash_pkg.sv
rtl/dhash_ram.sv
rtl/dhash_rem.sv
rtl/double_hash_table.sv
tb/sv/tb_double_hash_table.sv
